>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pps_pkg.sv
// Types and constants of the preemptive priority scheduler.
`timescale 1ns / 1ps
package pps_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int TIME_W = 20;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  slot;
    logic [15:0] arrival_time;
    logic [15:0] burst_length;
    logic [7:0]  priority_level;
  } cmd_t;

  typedef struct packed {
    logic [3:0]        served_slot;
    logic              idle;
    logic              finished;
    logic [TIME_W-1:0] waiting_time;
    logic [TIME_W-1:0] turnaround_time;
    logic              all_done;
  } result_t;

  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [7:0]  prio;
  } entry_t;

endpackage

>>> rtl/preemptive_priority_scheduler.sv
// A tick scans N = min(processes_in_use, 16) task slots, one entry per cycle from the task
// memory read port, then writes back the chosen entry and registers the result with done;
// busy holds off new items until then. Loads and restarts one per cycle while no tick runs.
// Reset (rst, synchronous): clock to zero, all remaining work cleared, processes_in_use 0.
// The done strobe cannot be stalled by the receiver.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module preemptive_priority_scheduler (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pps_pkg::cmd_t    cmd,
  output logic             done,
  output pps_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [4:0]       cfg_data
);

  localparam int TW = pps_pkg::TIME_W;

  pps_pkg::state_t st, st_next;
  pps_pkg::entry_t mem [pps_pkg::MAX_TASKS];
  pps_pkg::entry_t rd_data, best, wd;
  pps_pkg::idx_t   rd_slot, wa, pick;
  pps_pkg::cnt_t   cnt, live, n_act;
  logic [pps_pkg::MAX_TASKS-1:0] loaded;
  logic [TW-1:0]   cur_time;
  logic [4:0]      procs;
  logic            rd_ok, issue, we, found, accept;
  logic [15:0]     rem_v;
  logic            runnable;
  logic [TW+1:0]   end_t, tat_d, wt_d;
  pps_pkg::result_t res_next;

  assign accept = start && !busy;
  assign n_act  = (32'(procs) > pps_pkg::MAX_TASKS) ? pps_pkg::CNT_W'(pps_pkg::MAX_TASKS)
                                                    : pps_pkg::CNT_W'(procs);

  always_comb begin
    st_next = st;
    unique case (st)
      pps_pkg::ST_IDLE: begin
        if (accept && cmd.operation == pps_pkg::OP_TICK) st_next = pps_pkg::ST_SCAN;
      end
      pps_pkg::ST_SCAN: begin
        if (cnt == n_act) st_next = pps_pkg::ST_UPDATE;
      end
      pps_pkg::ST_UPDATE: st_next = pps_pkg::ST_IDLE;
      default: st_next = pps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = 1'b1;
    issue = 1'b0;
    we    = 1'b0;
    wa    = pick;
    wd    = '{arrival: cmd.arrival_time, burst: cmd.burst_length,
              remaining: cmd.burst_length, prio: cmd.priority_level};
    unique case (st)
      pps_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (accept && cmd.operation == pps_pkg::OP_LOAD &&
            32'(cmd.slot) < pps_pkg::MAX_TASKS) begin
          we = 1'b1;
          wa = pps_pkg::IDX_W'(cmd.slot);
        end
      end
      pps_pkg::ST_SCAN: issue = (cnt < n_act);
      pps_pkg::ST_UPDATE: begin
        we = found;
        wd = best;
        wd.remaining = best.remaining - 16'd1;
      end
      default: busy = 1'b1;
    endcase
  end

  // scan evaluation
  always_comb begin
    rem_v    = loaded[rd_slot] ? rd_data.remaining : 16'd0;
    runnable = (rem_v != 16'd0) && (TW'(rd_data.arrival) <= cur_time);
  end

  // completion times, held to 0 .. TIME_MAX
  always_comb begin
    end_t = {2'b00, cur_time} + (TW+2)'(1);
    tat_d = end_t - (TW+2)'(best.arrival);
    wt_d  = tat_d - (TW+2)'(best.burst);
    res_next = '0;
    res_next.idle        = !found;
    res_next.served_slot = found ? 4'(pick) : 4'd0;
    if (found && best.remaining == 16'd1) begin
      res_next.finished = 1'b1;
      if (tat_d[TW+1])                       res_next.turnaround_time = '0;
      else if (tat_d > (TW+2)'(pps_pkg::TIME_MAX)) res_next.turnaround_time = pps_pkg::TIME_MAX;
      else                                   res_next.turnaround_time = tat_d[TW-1:0];
      if (wt_d[TW+1])                        res_next.waiting_time = '0;
      else if (wt_d > (TW+2)'(pps_pkg::TIME_MAX))  res_next.waiting_time = pps_pkg::TIME_MAX;
      else                                   res_next.waiting_time = wt_d[TW-1:0];
    end
    res_next.all_done = (live == '0) ||
                        (found && live == pps_pkg::CNT_W'(1) && best.remaining == 16'd1);
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (issue) rd_data <= mem[cnt[pps_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= pps_pkg::ST_IDLE;
      loaded   <= '0;
      cur_time <= '0;
      procs    <= '0;
      cnt      <= '0;
      live     <= '0;
      found    <= 1'b0;
      rd_ok    <= 1'b0;
      done     <= 1'b0;
    end else begin
      st    <= st_next;
      rd_ok <= issue;
      done  <= (st == pps_pkg::ST_UPDATE);
      if (cfg_we) procs <= cfg_data;
      if (we && st == pps_pkg::ST_IDLE) loaded[wa] <= 1'b1;
      if (accept && cmd.operation == pps_pkg::OP_RESTART) begin
        loaded   <= '0;
        cur_time <= '0;
      end
      if (accept && cmd.operation == pps_pkg::OP_TICK) begin
        cnt   <= '0;
        live  <= '0;
        found <= 1'b0;
      end
      if (issue) cnt <= cnt + pps_pkg::CNT_W'(1);
      if (rd_ok) begin
        if (rem_v != 16'd0) live <= live + pps_pkg::CNT_W'(1);
        if (runnable && (!found || rd_data.prio < best.prio)) found <= 1'b1;
      end
      if (st == pps_pkg::ST_UPDATE && cur_time != pps_pkg::TIME_MAX)
        cur_time <= cur_time + TW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) rd_slot <= cnt[pps_pkg::IDX_W-1:0];
    if (rd_ok && runnable && (!found || rd_data.prio < best.prio)) begin
      best <= rd_data;
      pick <= rd_slot;
    end
    if (st == pps_pkg::ST_UPDATE) result <= res_next;
  end

  `ASSERT_CLK(a_done_from_update, done |-> $past(st == pps_pkg::ST_UPDATE), "stray done")
  `ASSERT_CLK(a_read_in_scan, rd_ok |-> $past(st == pps_pkg::ST_SCAN), "read outside scan")
  `ASSERT_CLK(a_tick_starts_scan, (accept && cmd.operation == pps_pkg::OP_TICK) |=> st == pps_pkg::ST_SCAN, "tick did not scan")
  `ASSERT_CLK(a_finish_not_idle, (done && result.finished) |-> !result.idle, "idle tick finished")
  `ASSERT_CLK(a_live_bound, live <= n_act || st == pps_pkg::ST_IDLE, "live count too large")

endmodule

>>> verif/tb_preemptive_priority_scheduler.sv
// Self-checking testbench for the preemptive priority scheduler: directed and random items.
`timescale 1ns / 1ps
module tb_preemptive_priority_scheduler;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned ITEM_TARGET = 1500;
  localparam int unsigned CALM_ITEMS = 450;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT = 500000;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  pps_pkg::cmd_t    cmd;
  logic             done;
  pps_pkg::result_t result;
  logic             cfg_we;
  logic [4:0]       cfg_data;

  preemptive_priority_scheduler i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // scheduler state as predicted from the accepted items
  logic [15:0] slot_arrival [pps_pkg::MAX_TASKS] = '{default: '0};
  logic [15:0] slot_burst   [pps_pkg::MAX_TASKS] = '{default: '0};
  logic [15:0] slot_left    [pps_pkg::MAX_TASKS] = '{default: '0};
  logic [7:0]  slot_prio    [pps_pkg::MAX_TASKS] = '{default: '0};
  logic [pps_pkg::TIME_W-1:0] sched_now = '0;
  logic [4:0]  use_count = '0;

  pps_pkg::result_t pending_results [$];

  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned finishes_seen = 0;
  int unsigned idles_seen = 0;
  int unsigned cycle_count = 0;
  bit idle_on = 1'b0;

  function automatic logic [pps_pkg::TIME_W-1:0] clamp_time(input longint v);
    if (v < 0) return '0;
    if (v > longint'(pps_pkg::TIME_MAX)) return pps_pkg::TIME_MAX;
    return v[pps_pkg::TIME_W-1:0];
  endfunction

  function automatic pps_pkg::cmd_t make_cmd(input logic [1:0] op, input logic [3:0] s,
                                             input logic [15:0] a, input logic [15:0] b,
                                             input logic [7:0] p);
    pps_pkg::cmd_t c;
    c.operation = op;
    c.slot = s;
    c.arrival_time = a;
    c.burst_length = b;
    c.priority_level = p;
    return c;
  endfunction

  task automatic schedule_item(input pps_pkg::cmd_t c);
    int n;
    int pick;
    bit found;
    longint fin;
    pps_pkg::result_t r;
    r = '0;
    case (c.operation)
      pps_pkg::OP_LOAD: begin
        slot_arrival[c.slot] = c.arrival_time;
        slot_burst[c.slot] = c.burst_length;
        slot_left[c.slot] = c.burst_length;
        slot_prio[c.slot] = c.priority_level;
      end
      pps_pkg::OP_RESTART: begin
        sched_now = '0;
        for (int i = 0; i < pps_pkg::MAX_TASKS; i++) slot_left[i] = '0;
      end
      pps_pkg::OP_TICK: begin
        n = (int'(use_count) > pps_pkg::MAX_TASKS) ? pps_pkg::MAX_TASKS : int'(use_count);
        found = 1'b0;
        pick = 0;
        for (int i = 0; i < n; i++) begin
          if (slot_left[i] != 16'd0 && pps_pkg::TIME_W'(slot_arrival[i]) <= sched_now) begin
            if (!found || slot_prio[i] < slot_prio[pick]) begin
              pick = i;
              found = 1'b1;
            end
          end
        end
        if (found) begin
          slot_left[pick] = slot_left[pick] - 16'd1;
          r.served_slot = pick[3:0];
          if (slot_left[pick] == 16'd0) begin
            fin = longint'(sched_now) + longint'(1);
            r.finished = 1'b1;
            r.turnaround_time = clamp_time(fin - longint'(slot_arrival[pick]));
            r.waiting_time = clamp_time(fin - longint'(slot_arrival[pick])
                                        - longint'(slot_burst[pick]));
          end
        end else begin
          r.idle = 1'b1;
        end
        if (sched_now < pps_pkg::TIME_MAX) sched_now = sched_now + pps_pkg::TIME_W'(1);
        r.all_done = 1'b1;
        for (int i = 0; i < n; i++) if (slot_left[i] != 16'd0) r.all_done = 1'b0;
        pending_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    errors++;
  endtask

  task automatic check_result(input pps_pkg::result_t got);
    pps_pkg::result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with none pending", longint'(1), longint'(0));
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    if (got.idle) idles_seen++;
    if (got.finished) finishes_seen++;
    if (got.served_slot !== want.served_slot)
      report_mismatch("served_slot", longint'(got.served_slot), longint'(want.served_slot));
    if (got.idle !== want.idle)
      report_mismatch("idle", longint'(got.idle), longint'(want.idle));
    if (got.finished !== want.finished)
      report_mismatch("finished", longint'(got.finished), longint'(want.finished));
    if (got.waiting_time !== want.waiting_time)
      report_mismatch("waiting_time", longint'(got.waiting_time),
                      longint'(want.waiting_time));
    if (got.turnaround_time !== want.turnaround_time)
      report_mismatch("turnaround_time", longint'(got.turnaround_time),
                      longint'(want.turnaround_time));
    if (got.all_done !== want.all_done)
      report_mismatch("all_done", longint'(got.all_done), longint'(want.all_done));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (done) check_result(result);
      if (cfg_we) use_count = cfg_data;
      if (start && !busy) schedule_item(cmd);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d results pending", pending_results.size());
      $display("[preemptive_priority_scheduler] ERROR");
      $finish;
    end
  end

  task automatic send_item(input pps_pkg::cmd_t c);
    int unsigned gap;
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    if (c.operation != OP_UNUSED) items_sent++;
    if (idle_on && $urandom_range(99) < 20) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_use(input logic [4:0] n);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_empty_table();
    send_item(make_cmd(pps_pkg::OP_TICK, 4'd0, 16'd0, 16'd0, 8'd0));
    set_use(5'd16);
    send_item(make_cmd(pps_pkg::OP_TICK, 4'hf, 16'hffff, 16'hffff, 8'hff));
  endtask

  task automatic test_priority_order();
    set_use(5'd4);
    send_item(make_cmd(pps_pkg::OP_LOAD, 4'd0, 16'd0, 16'd2, 8'd5));
    send_item(make_cmd(pps_pkg::OP_LOAD, 4'd1, 16'd1, 16'd1, 8'd2));
    send_item(make_cmd(pps_pkg::OP_LOAD, 4'd2, 16'd0, 16'd1, 8'd5));
    send_item(make_cmd(pps_pkg::OP_LOAD, 4'd3, 16'd0, 16'd0, 8'd0));
    repeat (2) send_item(make_cmd(pps_pkg::OP_TICK, 4'd0, 16'd0, 16'd0, 8'd0));
    // late load at priority 0 is served ahead of the waiting tasks
    send_item(make_cmd(pps_pkg::OP_LOAD, 4'd3, 16'd0, 16'd1, 8'd0));
    repeat (5) send_item(make_cmd(pps_pkg::OP_TICK, 4'd0, 16'd0, 16'd0, 8'd0));
  endtask

  task automatic test_field_extremes();
    set_use(5'd31);
    send_item(make_cmd(pps_pkg::OP_LOAD, 4'd15, 16'hffff, 16'hffff, 8'hff));
    send_item(make_cmd(pps_pkg::OP_LOAD, 4'd0, 16'd0, 16'd1, 8'd0));
    repeat (2) send_item(make_cmd(pps_pkg::OP_TICK, 4'd0, 16'd0, 16'd0, 8'd0));
    send_item(make_cmd(OP_UNUSED, 4'hf, 16'hffff, 16'hffff, 8'hff));
    send_item(make_cmd(pps_pkg::OP_RESTART, 4'hf, 16'hffff, 16'hffff, 8'hff));
    send_item(make_cmd(pps_pkg::OP_TICK, 4'd0, 16'd0, 16'd0, 8'd0));
    set_use(5'd0);
    send_item(make_cmd(pps_pkg::OP_LOAD, 4'd0, 16'd0, 16'd3, 8'd1));
    send_item(make_cmd(pps_pkg::OP_TICK, 4'd0, 16'd0, 16'd0, 8'd0));
  endtask

  task automatic run_schedule_batch();
    int unsigned n;
    int unsigned k;
    int unsigned ticks;
    int unsigned longest;
    int unsigned a;
    int unsigned b;
    logic [3:0] s;
    logic [7:0] p;
    send_item(make_cmd(pps_pkg::OP_RESTART, 4'($urandom_range(15)), 16'($urandom),
                       16'($urandom), 8'($urandom)));
    n = (int'(use_count) > pps_pkg::MAX_TASKS) ? pps_pkg::MAX_TASKS : int'(use_count);
    if (n == 0) n = 1;
    k = $urandom_range(1, n);
    ticks = 0;
    longest = 0;
    repeat (k) begin
      s = ($urandom_range(99) < 80) ? 4'($urandom_range(n - 1)) : 4'($urandom_range(15));
      a = $urandom_range(12);
      b = ($urandom_range(99) < 90) ? $urandom_range(1, 5) : $urandom_range(0, 12);
      p = ($urandom_range(99) < 50) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
      ticks += b;
      if (a > longest) longest = a;
      send_item(make_cmd(pps_pkg::OP_LOAD, s, 16'(a), 16'(b), p));
    end
    ticks += longest + $urandom_range(1, 4);
    repeat (ticks) begin
      if ($urandom_range(99) < 4) begin
        s = 4'($urandom_range(n - 1));
        send_item(make_cmd(pps_pkg::OP_LOAD, s, 16'($urandom_range(30)),
                           16'($urandom_range(1, 4)), 8'($urandom_range(255))));
      end else if ($urandom_range(199) == 0) begin
        send_item(make_cmd(pps_pkg::OP_RESTART, 4'd0, 16'd0, 16'd0, 8'd0));
      end
      send_item(make_cmd(pps_pkg::OP_TICK, 4'($urandom_range(15)), 16'($urandom),
                         16'($urandom), 8'($urandom)));
    end
  endtask

  task automatic run_noise();
    repeat ($urandom_range(4, 12))
      send_item(make_cmd(2'($urandom_range(3)), 4'($urandom_range(15)),
                         16'($urandom_range(65535)), 16'($urandom_range(65535)),
                         8'($urandom_range(255))));
  endtask

  function automatic logic [4:0] pick_use();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 5'($urandom_range(1, 6));
    if (r < 85) return 5'($urandom_range(7, 16));
    if (r < 92) return 5'd0;
    return 5'($urandom_range(17, 31));
  endfunction

  task automatic test_random_schedules();
    idle_on = 1'b0;
    while (items_sent < ITEM_TARGET) begin
      if (idle_on == 1'b0 && items_sent >= CALM_ITEMS) begin
        // hold the sender until every pending result is out
        wait_drained();
        idle_on = 1'b1;
      end
      if ($urandom_range(99) < 15) set_use(pick_use());
      if ($urandom_range(99) < 75) run_schedule_batch();
      else run_noise();
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_on = 1'b1;
    test_empty_table();
    test_priority_order();
    test_field_extremes();
    test_random_schedules();
    wait_drained();
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", longint'(pending_results.size()),
                      longint'(0));
    $display("sent %0d items, checked %0d tick results", items_sent, results_checked);
    $display("%0d tasks completed, %0d idle ticks, %0d mismatches",
             finishes_seen, idles_seen, errors);
    if (errors == 0) begin
      $display("[preemptive_priority_scheduler] OK");
    end else begin
      $display("[preemptive_priority_scheduler] ERROR");
    end
    $finish;
  end

endmodule
